// ----- sv/ccsls_pkg.sv -----
`default_nettype none

package ccsls_pkg;

  // special source bytes
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_NEWLINE   = 8'h0A;
  localparam logic [7:0] CH_SLASH     = 8'h2F;
  localparam logic [7:0] CH_STAR      = 8'h2A;
  localparam logic [7:0] CH_SPACE     = 8'h20;
  localparam logic [7:0] CH_TAB       = 8'h09;

  // one-character lookahead
  typedef enum logic [1:0] {
    PEND_NONE  = 2'd0,
    PEND_BSL   = 2'd1,
    PEND_SLASH = 2'd2,
    PEND_STAR  = 2'd3
  } pend_e;

  // result kinds
  typedef enum logic [1:0] {
    KIND_CHAR  = 2'd0,
    KIND_LINE  = 2'd1,
    KIND_ERROR = 2'd2
  } kind_e;

  // one result transaction
  typedef struct packed {
    kind_e       kind;
    logic [7:0]  ch;
    logic [31:0] line;
    logic        last;
  } result_t;

  // results of one accepted item, handed from front to queue
  typedef struct packed {
    logic [1:0] n;
    result_t    res0;
    result_t    res1;
  } emit_t;

endpackage

`default_nettype wire

// ----- sv/ccsls_front.sv -----
`default_nettype none

module ccsls_front (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           take_i,
  input  wire logic [7:0]     in_char_i,
  input  wire logic           end_of_input_i,
  output ccsls_pkg::emit_t    emit_o
);
  import ccsls_pkg::*;

  // character classes
  typedef struct packed {
    logic is_bsl;
    logic is_nl;
    logic is_slash;
    logic is_star;
    logic is_blank;
  } char_class_t;

  char_class_t cls;

  pend_e       pend_q, pend_d;
  logic        cm_q, cm_d;
  logic        snb_q, snb_d;
  logic        lhc_q, lhc_d;
  logic [31:0] cnt_q, cnt_d;
  logic        halt_q, halt_d;
  logic [31:0] cnt_inc;

  logic        pre_v;
  logic [7:0]  pre_ch;
  logic        post_v;
  kind_e       post_kind;
  logic [7:0]  post_ch;
  logic        do_fresh;

  // classify the incoming byte
  always_comb begin
    cls.is_bsl   = (in_char_i == CH_BACKSLASH);
    cls.is_nl    = (in_char_i == CH_NEWLINE);
    cls.is_slash = (in_char_i == CH_SLASH);
    cls.is_star  = (in_char_i == CH_STAR);
    cls.is_blank = (in_char_i == CH_SPACE) || (in_char_i == CH_TAB);
  end

  // saturating newline counter
  assign cnt_inc = (&cnt_q) ? cnt_q : cnt_q + 32'd1;

  // one step of the filter: a leading result from the lookahead, then the fresh char
  always_comb begin
    pend_d    = pend_q;
    cm_d      = cm_q;
    snb_d     = snb_q;
    lhc_d     = lhc_q;
    cnt_d     = cnt_q;
    halt_d    = halt_q;
    pre_v     = 1'b0;
    pre_ch    = CH_SLASH;
    post_v    = 1'b0;
    post_kind = KIND_CHAR;
    post_ch   = 8'd0;
    do_fresh  = 1'b0;
    if (take_i && !halt_q) begin
      pend_d = PEND_NONE;
      if (end_of_input_i) begin
        if (pend_q == PEND_BSL) begin
          post_v    = 1'b1;
          post_kind = KIND_ERROR;
          halt_d    = 1'b1;
        end else begin
          if (pend_q == PEND_SLASH) begin
            pre_v  = 1'b1;
            pre_ch = CH_SLASH;
            lhc_d  = 1'b1;
          end
          if (lhc_d) begin
            post_v    = 1'b1;
            post_kind = KIND_LINE;
          end
        end
        cm_d  = 1'b0;
        snb_d = 1'b0;
        lhc_d = 1'b0;
      end else begin
        unique case (pend_q)
          PEND_BSL: begin
            if (cls.is_nl) begin
              cnt_d = cnt_inc;
            end else begin
              if (!cm_q) begin
                pre_v  = 1'b1;
                pre_ch = CH_BACKSLASH;
                snb_d  = 1'b1;
                lhc_d  = 1'b1;
              end
              do_fresh = 1'b1;
            end
          end
          PEND_SLASH: begin
            if (cls.is_star) begin
              cm_d = 1'b1;
            end else begin
              pre_v    = 1'b1;
              pre_ch   = CH_SLASH;
              snb_d    = 1'b1;
              lhc_d    = 1'b1;
              do_fresh = 1'b1;
            end
          end
          PEND_STAR: begin
            if (cls.is_slash) begin
              cm_d = 1'b0;
            end else begin
              do_fresh = 1'b1;
            end
          end
          PEND_NONE: begin
            do_fresh = 1'b1;
          end
          default: begin
            do_fresh = 1'b1;
          end
        endcase
        // fresh character handling
        if (do_fresh) begin
          if (cls.is_bsl) begin
            pend_d = PEND_BSL;
          end else if (cm_d) begin
            if (cls.is_star) begin
              pend_d = PEND_STAR;
            end else if (cls.is_nl) begin
              cnt_d = cnt_inc;
            end
          end else if (cls.is_slash) begin
            pend_d = PEND_SLASH;
          end else if (cls.is_nl) begin
            cnt_d = cnt_inc;
            if (snb_d) begin
              post_v    = 1'b1;
              post_kind = KIND_LINE;
              snb_d     = 1'b0;
              lhc_d     = 1'b0;
            end
          end else begin
            post_v  = 1'b1;
            post_ch = in_char_i;
            lhc_d   = 1'b1;
            if (!cls.is_blank) begin
              snb_d = 1'b1;
            end
          end
        end
      end
    end
  end

  // pack results for the queue
  always_comb begin
    emit_o.n         = {1'b0, pre_v} + {1'b0, post_v};
    emit_o.res1.kind = post_kind;
    emit_o.res1.ch   = post_ch;
    emit_o.res1.line = cnt_d;
    emit_o.res1.last = 1'b1;
    if (pre_v) begin
      emit_o.res0.kind = KIND_CHAR;
      emit_o.res0.ch   = pre_ch;
      emit_o.res0.line = cnt_q;
      emit_o.res0.last = !post_v;
    end else begin
      emit_o.res0 = emit_o.res1;
    end
  end

  // filter state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= PEND_NONE;
      cm_q   <= 1'b0;
      snb_q  <= 1'b0;
      lhc_q  <= 1'b0;
      cnt_q  <= 32'd0;
      halt_q <= 1'b0;
    end else begin
      pend_q <= pend_d;
      cm_q   <= cm_d;
      snb_q  <= snb_d;
      lhc_q  <= lhc_d;
      cnt_q  <= cnt_d;
      halt_q <= halt_d;
    end
  end

  // once halted, stays halted
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    halt_q |=> halt_q)
    else $error("halt flag cleared without reset");

  // halting clears the lookahead and comment state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    halt_q |-> (pend_q == PEND_NONE) && !cm_q && !lhc_q)
    else $error("state left over while halted");

  // no results without an accepted transaction
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !take_i |-> (emit_o.n == 2'd0))
    else $error("results produced without a transaction");

endmodule

`default_nettype wire

// ----- sv/ccsls_queue.sv -----
`default_nettype none

module ccsls_queue #(
  parameter int DEPTH = 4
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire ccsls_pkg::emit_t wr_i,
  output logic                full_o,
  output logic                empty_o,
  input  wire logic           pop_i,
  output ccsls_pkg::result_t  rd_o
);
  import ccsls_pkg::*;

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  result_t         mem [DEPTH];
  logic [PW-1:0]   wr_q, wr_d;
  logic [PW-1:0]   rd_q, rd_d;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic            rd_en;
  logic [PW-1:0]   wr_nxt;

  // pointer step with wrap at the queue depth
  function automatic logic [PW-1:0] wrap_inc(logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  // status: room for two results keeps the front going
  assign empty_o = (cnt_q == CW'(0));
  assign full_o  = (cnt_q > CW'(DEPTH - 2));
  assign rd_en   = pop_i && !empty_o;
  assign wr_nxt  = wrap_inc(wr_q);
  assign rd_o    = mem[rd_q];

  // pointers and fill count
  always_comb begin
    wr_d  = (wr_i.n == 2'd0) ? wr_q : ((wr_i.n == 2'd1) ? wr_nxt : wrap_inc(wr_nxt));
    rd_d  = rd_en ? wrap_inc(rd_q) : rd_q;
    cnt_d = cnt_q + CW'(wr_i.n) - CW'(rd_en);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // result storage, up to two writes a cycle
  always_ff @(posedge clk_i) begin
    if (wr_i.n != 2'd0) begin
      mem[wr_q] <= wr_i.res0;
    end
    if (wr_i.n == 2'd2) begin
      mem[wr_nxt] <= wr_i.res1;
    end
  end

  // fill count stays in range
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(DEPTH))
    else $error("queue fill count overflow");

  // writes never exceed free room
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_i.n != 2'd0) |-> (CW'(wr_i.n) <= CW'(DEPTH) - cnt_q))
    else $error("queue written beyond its room");

  // a read with no write drops the count by one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rd_en && (wr_i.n == 2'd0)) |=> (cnt_q == $past(cnt_q) - CW'(1)))
    else $error("queue count wrong after read");

endmodule

`default_nettype wire

// ----- sv/c_comment_strip_line_splice.sv -----
// C comment stripper and line splicer. One source byte (or an end-of-input mark) is taken
// per cycle through push/full and its zero, one or two results are placed in a result queue
// in the same cycle; they are readable through empty/pop from the next cycle on, one per
// cycle. An item thus enters every cycle as long as the queue has room for two results; the
// sustained rate is set by the single read port of the result queue, so a stream that
// produces one result per item runs at one item per cycle and items that produce two
// results (a kept slash or backslash followed by another result) need a read for each
// result. After a backslash at end of input the block reports an error and then takes
// items without producing results until reset. Newline count saturates at all ones.
`default_nettype none

module c_comment_strip_line_splice #(
  parameter int DEPTH = 4
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push,
  output logic             full,
  input  wire logic [7:0]  in_char_i,
  input  wire logic        end_of_input_i,
  output logic             empty,
  input  wire logic        pop,
  output logic [1:0]       out_kind_o,
  output logic [7:0]       out_char_o,
  output logic [31:0]      line_number_o,
  output logic             is_last_o
);
  import ccsls_pkg::*;

  logic    take;
  emit_t   emit;
  result_t head;

  assign take = push && !full;

  // front: classify and filter
  ccsls_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .take_i         (take),
    .in_char_i      (in_char_i),
    .end_of_input_i (end_of_input_i),
    .emit_o         (emit)
  );

  // back: result queue
  ccsls_queue #(
    .DEPTH (DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (emit),
    .full_o  (full),
    .empty_o (empty),
    .pop_i   (pop),
    .rd_o    (head)
  );

  // result ports
  assign out_kind_o    = head.kind;
  assign out_char_o    = head.ch;
  assign line_number_o = head.line;
  assign is_last_o     = head.last;

endmodule

`default_nettype wire

// ----- tb/c_comment_strip_line_splice_tb.sv -----
`timescale 1ns / 100ps

module c_comment_strip_line_splice_tb;
  import ccsls_pkg::*;

  // predicts the stripped stream and checks each result transaction in order
  class splice_scoreboard;
    pend_e       pend;
    bit          in_cmt;
    bit          nonblank;
    bit          has_chars;
    bit          halted;
    logic [31:0] nl_count;
    result_t     awaited[$];
    result_t     fresh[$];
    int          errors;

    function new();
      pend      = PEND_NONE;
      in_cmt    = 1'b0;
      nonblank  = 1'b0;
      has_chars = 1'b0;
      halted    = 1'b0;
      nl_count  = '0;
      errors    = 0;
    endfunction

    function void flag(string msg);
      errors++;
      if (errors <= 10) $display("%0t: %s", $time, msg);
    endfunction

    function void add(kind_e k, logic [7:0] c);
      result_t r;
      if (fresh.size() >= 2) return;
      r.kind = k;
      r.ch   = c;
      r.line = nl_count;
      r.last = 1'b0;
      fresh.push_back(r);
    endfunction

    function void bump();
      if (nl_count != '1) nl_count = nl_count + 1;
    endfunction

    function void keep(logic [7:0] c);
      if (c != CH_SPACE && c != CH_TAB) nonblank = 1'b1;
      has_chars = 1'b1;
      add(KIND_CHAR, c);
    endfunction

    function void close_line();
      add(KIND_LINE, 8'h00);
      nonblank  = 1'b0;
      has_chars = 1'b0;
    endfunction

    // a character with no lookahead pending
    function void take_fresh(logic [7:0] c);
      if (c == CH_BACKSLASH) begin
        pend = PEND_BSL;
      end else if (in_cmt) begin
        if (c == CH_STAR) pend = PEND_STAR;
        else if (c == CH_NEWLINE) bump();
      end else if (c == CH_SLASH) begin
        pend = PEND_SLASH;
      end else if (c == CH_NEWLINE) begin
        bump();
        if (nonblank) close_line();
      end else begin
        keep(c);
      end
    endfunction

    // called for every accepted input transaction
    function void note_item(logic [7:0] c, bit eoi);
      pend_e   p;
      result_t r;
      p = pend;
      fresh.delete();
      if (halted) return;
      pend = PEND_NONE;
      if (eoi) begin
        if (p == PEND_BSL) begin
          add(KIND_ERROR, 8'h00);
          halted = 1'b1;
        end else begin
          if (p == PEND_SLASH) keep(CH_SLASH);
          if (has_chars) close_line();
        end
        in_cmt    = 1'b0;
        nonblank  = 1'b0;
        has_chars = 1'b0;
      end else if (p == PEND_BSL) begin
        if (c == CH_NEWLINE) begin
          bump();
        end else begin
          if (!in_cmt) keep(CH_BACKSLASH);
          take_fresh(c);
        end
      end else if (p == PEND_SLASH) begin
        if (c == CH_STAR) begin
          in_cmt = 1'b1;
        end else begin
          keep(CH_SLASH);
          take_fresh(c);
        end
      end else if (p == PEND_STAR) begin
        if (c == CH_SLASH) in_cmt = 1'b0;
        else take_fresh(c);
      end else begin
        take_fresh(c);
      end
      if (fresh.size() > 0) begin
        r = fresh[fresh.size() - 1];
        r.last = 1'b1;
        fresh[fresh.size() - 1] = r;
      end
      foreach (fresh[i]) awaited.push_back(fresh[i]);
    endfunction

    // called for every accepted result transaction
    function void check_result(logic [1:0] k, logic [7:0] c, logic [31:0] ln, logic lst);
      result_t e;
      if (awaited.size() == 0) begin
        flag($sformatf("unexpected result: kind %0d char %02h line %0d last %0b",
                       k, c, ln, lst));
        return;
      end
      e = awaited.pop_front();
      if (k !== e.kind || c !== e.ch || ln !== e.line || lst !== e.last)
        flag($sformatf("mismatch: expected kind %0d char %02h line %0d last %0b, got kind %0d char %02h line %0d last %0b",
                       e.kind, e.ch, e.line, e.last, k, c, ln, lst));
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        push_r = 1'b0;
  logic        full_w;
  logic [7:0]  in_char_r = 8'h00;
  logic        eoi_r = 1'b0;
  logic        empty_w;
  logic        pop_r = 1'b0;
  logic [1:0]  out_kind_w;
  logic [7:0]  out_char_w;
  logic [31:0] line_number_w;
  logic        is_last_w;

  splice_scoreboard sb = new();
  int n_sent = 0;
  int stall_left = 0;
  bit quiet_in = 1'b0;
  bit quiet_out = 1'b0;
  bit tail = 1'b0;

  c_comment_strip_line_splice u_top (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .push           (push_r),
    .full           (full_w),
    .in_char_i      (in_char_r),
    .end_of_input_i (eoi_r),
    .empty          (empty_w),
    .pop            (pop_r),
    .out_kind_o     (out_kind_w),
    .out_char_o     (out_char_w),
    .line_number_o  (line_number_w),
    .is_last_o      (is_last_w)
  );

  // clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // result side: check accepted transactions, stall in random bursts
  always @(posedge clk) begin
    if (rst_n && pop_r && empty_w === 1'b0)
      sb.check_result(out_kind_w, out_char_w, line_number_w, is_last_w);
    if (stall_left > 0) stall_left--;
    else if (!tail && !quiet_out && $urandom_range(0, 7) == 0)
      stall_left = $urandom_range(1, 17);
    if (!tail && $urandom_range(0, 199) == 0) quiet_out = !quiet_out;
    pop_r <= (stall_left == 0);
  end

  // one input transaction, with an optional gap before it
  task automatic send_item(logic [7:0] c, bit eoi);
    int gap;
    if (!quiet_in && $urandom_range(0, 9) == 0) begin
      gap = $urandom_range(1, 17);
      push_r <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push_r    <= 1'b1;
    in_char_r <= c;
    eoi_r     <= eoi;
    do @(posedge clk); while (full_w !== 1'b0);
    sb.note_item(c, eoi);
    n_sent++;
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_item(s[i], 1'b0);
  endtask

  task automatic send_eoi();
    send_item(8'($urandom_range(0, 255)), 1'b1);
  endtask

  // mostly source-like fragments, some raw noise
  task automatic random_fragment();
    int n;
    if ($urandom_range(0, 29) == 0) quiet_in = !quiet_in;
    if (tail) quiet_in = 1'b1;
    case ($urandom_range(0, 11))
      0, 1: begin
        n = $urandom_range(1, 6);
        repeat (n) send_item(8'($urandom_range(8'h21, 8'h7E)), 1'b0);
      end
      2: begin
        n = $urandom_range(1, 3);
        repeat (n) send_item($urandom_range(0, 1) ? CH_SPACE : CH_TAB, 1'b0);
      end
      3, 4: send_item(CH_NEWLINE, 1'b0);
      5: send_text("\\\n");
      6, 7: begin
        send_text("/*");
        n = $urandom_range(0, 8);
        repeat (n) begin
          case ($urandom_range(0, 5))
            0: send_item(CH_STAR, 1'b0);
            1: send_item(CH_NEWLINE, 1'b0);
            2: send_item(CH_BACKSLASH, 1'b0);
            3: send_item(CH_SLASH, 1'b0);
            4: send_item(CH_SPACE, 1'b0);
            default: send_item(8'($urandom_range(0, 255)), 1'b0);
          endcase
        end
        // an unterminated comment now and then
        if ($urandom_range(0, 3) != 0) send_text("*/");
      end
      8: begin
        send_item(CH_SLASH, 1'b0);
        send_item(8'($urandom_range(0, 255)), 1'b0);
      end
      9: begin
        send_item(CH_BACKSLASH, 1'b0);
        send_item(8'($urandom_range(0, 255)), 1'b0);
      end
      10: begin
        n = $urandom_range(1, 3);
        repeat (n) send_item(8'($urandom_range(0, 255)), 1'b0);
      end
      default: begin
        // a pending backslash at end of input would halt the block
        if (sb.pend == PEND_BSL) send_item(CH_NEWLINE, 1'b0);
        else send_eoi();
      end
    endcase
  endtask

  // main sequence
  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: byte extremes, splice, stray backslash, blank-only line,
    // stray slash, comment with newline, star and backslash inside it
    send_item(8'h00, 1'b0);
    send_item(8'hFF, 1'b0);
    send_text("\\\n\\q\n \t\n/x/*\n*\\k*//");
    // end of input with a pending slash, then with a pending star, then empty
    send_eoi();
    send_text("/**");
    send_eoi();
    send_eoi();

    // random source-like stream, idling on both sides
    while (n_sent < 900) random_fragment();
    // last stretch without idling
    tail = 1'b1;
    while (n_sent < 1060) random_fragment();

    // backslash at end of input halts the block; later items give nothing
    send_item(CH_BACKSLASH, 1'b0);
    send_eoi();
    repeat (4) send_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    push_r <= 1'b0;

    while (sb.awaited.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // run limit
  initial begin
    #5000000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
